// ----- rtl/jvhs_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// jvhs_pkg: shared types and constants of the joystick velocity and heading
// shaper.
// ---------------------------------------------------------------------------
package jvhs_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_HDG,
    ST_SQRT,
    ST_MULX,
    ST_MULY,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef enum logic [0:0] {
    REG_SIDE_MODE   = 1'b0,
    REG_SPEED_LIMIT = 1'b1
  } reg_index_t;

  localparam logic [1:0] ROT_NONE  = 2'd0;
  localparam logic [1:0] ROT_LEFT  = 2'd1;
  localparam logic [1:0] ROT_RIGHT = 2'd2;

  localparam logic [1:0] SIDE_MODE_RESET   = ROT_LEFT;
  localparam logic [8:0] SPEED_LIMIT_RESET = 9'd255;

  localparam logic signed [9:0] FULL_SPEED = 10'sd255;
  localparam logic signed [9:0] DIAG_SPEED = 10'sd180;

  localparam logic [11:0] NEAR_LIMIT = 12'd700;

  // divide by five: multiply by 205, drop ten bits (exact below 1024)
  localparam logic [15:0] DIV5_MUL   = 16'd205;
  // divide by ten: multiply by 13, drop seven bits (exact below 69)
  localparam logic [9:0]  DIV10_MUL  = 10'd13;
  localparam logic [5:0]  TURN_STEPS = 6'd10;

  localparam logic signed [5:0]  TURN_STEPS_S = 6'sd10;
  localparam logic signed [13:0] FULL_TURN    = 14'sd3600;
  localparam logic signed [13:0] TOP_HEADING  = 14'sd3599;

  localparam logic [4:0] SQRT_STEPS = 5'd9;
  localparam logic [4:0] DIV_STEPS  = 5'd17;

endpackage : jvhs_pkg
`default_nettype wire

// ----- rtl/joystick_velocity_heading_shaper.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// joystick_velocity_heading_shaper: control sample to velocity and heading
//
// A sample transaction (sample_valid, sample_stall) carries a d-pad mask,
// the left stick, both triggers and a range reading. A result transaction
// (result_valid, result_stall) returns the shaped velocity, the heading
// target and the near flag, one result per sample.
// A sample runs from acceptance to the output register through the squares,
// the heading update, the nine-step bit-pair square root and, only when the
// vector exceeds the speed limit and is scaled, the seventeen-step restoring
// division of both axes by the root. One sample is in flight at a time;
// sample_stall is low only while the sequencer is idle, and a new sample is
// taken while the previous result still waits in the output register.
// If the receiver stalls, the result holds and the sequencer waits in its
// final step until the output register is free. The configuration channel
// is always ready; the user writes it only between samples, which the block
// does not enforce. Reset clears heading and turn remainder, sets side mode
// to left side and the speed limit to 255, and empties the output register.
// ---------------------------------------------------------------------------
module joystick_velocity_heading_shaper (
  input  wire                clk,
  input  wire                rst,
  input  wire                sample_valid,
  output logic               sample_stall,
  input  wire  [7:0]         dpad_mask,
  input  wire  signed [8:0]  stick_x,
  input  wire  signed [8:0]  stick_y,
  input  wire  [7:0]         trigger_right,
  input  wire  [7:0]         trigger_left,
  input  wire  [11:0]        distance_reading,
  output logic               result_valid,
  input  wire                result_stall,
  output logic signed [9:0]  vel_x,
  output logic signed [9:0]  vel_y,
  output logic [11:0]        heading_target,
  output logic               near_flag,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [0:0]         cfg_index,
  input  wire  [8:0]         cfg_data
);
  import jvhs_pkg::*;

  state_t state, state_next;

  logic [1:0]  side_mode;
  logic [8:0]  speed_limit;

  logic signed [9:0] ux, uy, vx_c, vy_c, ax_c, ay_c;
  logic signed [8:0] tdiff_c;

  logic signed [9:0] vx_raw, vy_raw;
  logic [8:0]        ax, ay;
  logic              near;
  logic signed [8:0] tdiff;
  logic [5:0]        om_mag;
  logic              om_neg;
  logic [2:0]        q10;
  logic [3:0]        r10;

  logic [17:0] rad;
  logic [9:0]  sq_rem;
  logic [8:0]  sq_root;
  logic [16:0] nx, ny;
  logic [8:0]  rem_x, rem_y;
  logic [4:0]  cnt;
  logic        scaled;

  logic signed [4:0]  turn_rem;
  logic [11:0]        heading;

  logic [8:0]  mul_a, mul_b;
  logic [17:0] mul_p;

  logic [15:0] om_prod;
  logic [9:0]  q_prod;
  logic [2:0]  q10_c;
  logic [5:0]  q_times;

  logic signed [5:0]  r_s, rem_sum, tr_sum;
  logic signed [1:0]  inc;
  logic signed [3:0]  q_s;
  logic signed [13:0] hsum, hwrap;

  logic [11:0] sq_acc, sq_try;
  logic [9:0]  rx_sh, ry_sh, div_d;

  logic [9:0]        qx, qy;
  logic signed [9:0] fx, fy;
  logic              out_load;

  assign sample_stall = (state != ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_load     = (state == ST_FIN) && (!result_valid || !result_stall);

  // direction decode and side rotation
  always_comb begin
    ux = 10'(stick_x);
    uy = 10'(stick_y);
    if (dpad_mask != 8'd0) begin
      ux = '0;
      uy = '0;
      if (dpad_mask[0]) begin
        uy = FULL_SPEED;
      end else if (dpad_mask[1]) begin
        uy = -FULL_SPEED;
      end else if (dpad_mask[2]) begin
        ux = -FULL_SPEED;
      end else if (dpad_mask[3]) begin
        ux = FULL_SPEED;
      end else if (dpad_mask[4]) begin
        ux = -DIAG_SPEED;
        uy = DIAG_SPEED;
      end else if (dpad_mask[5]) begin
        ux = DIAG_SPEED;
        uy = DIAG_SPEED;
      end else if (dpad_mask[6]) begin
        ux = -DIAG_SPEED;
        uy = -DIAG_SPEED;
      end else begin
        ux = DIAG_SPEED;
        uy = -DIAG_SPEED;
      end
    end
    unique case (side_mode)
      ROT_LEFT: begin
        vx_c = uy;
        vy_c = -ux;
      end
      ROT_RIGHT: begin
        vx_c = -uy;
        vy_c = ux;
      end
      default: begin
        vx_c = ux;
        vy_c = uy;
      end
    endcase
    ax_c    = vx_c[9] ? -vx_c : vx_c;
    ay_c    = vy_c[9] ? -vy_c : vy_c;
    tdiff_c = $signed({1'b0, trigger_right}) - $signed({1'b0, trigger_left});
  end

  // shared multiplier
  always_comb begin
    mul_a = ax;
    mul_b = ax;
    case (state)
      ST_SQY: begin
        mul_a = ay;
        mul_b = ay;
      end
      ST_MULX: begin
        mul_a = ax;
        mul_b = speed_limit;
      end
      ST_MULY: begin
        mul_a = ay;
        mul_b = speed_limit;
      end
      default: begin
        mul_a = ax;
        mul_b = ax;
      end
    endcase
    mul_p = 18'(mul_a) * 18'(mul_b);
  end

  // turn arithmetic
  always_comb begin
    om_prod = 16'(tdiff < 0 ? 8'(-tdiff) : tdiff[7:0]) * DIV5_MUL;
    q_prod  = 10'(om_mag) * DIV10_MUL;
    q10_c   = q_prod[9:7];
    q_times = 6'(q10_c) * TURN_STEPS;

    r_s     = om_neg ? -$signed({2'b00, r10}) : $signed({2'b00, r10});
    rem_sum = 6'(turn_rem) + r_s;
    if (rem_sum >= TURN_STEPS_S) begin
      inc    = 2'sd1;
      tr_sum = rem_sum - TURN_STEPS_S;
    end else if (rem_sum <= -TURN_STEPS_S) begin
      inc    = -2'sd1;
      tr_sum = rem_sum + TURN_STEPS_S;
    end else begin
      inc    = 2'sd0;
      tr_sum = rem_sum;
    end
    q_s  = om_neg ? -$signed({1'b0, q10}) : $signed({1'b0, q10});
    hsum = $signed({2'b00, heading}) + 14'(q_s) + 14'(inc);
    if (hsum < 0) begin
      hwrap = hsum + FULL_TURN;
    end else if (hsum > TOP_HEADING) begin
      hwrap = hsum - FULL_TURN;
    end else begin
      hwrap = hsum;
    end
  end

  // square root and divider steps, final velocity and near clamp
  always_comb begin
    sq_acc = {sq_rem, rad[17:16]};
    sq_try = {1'b0, sq_root, 2'b01};
    div_d  = {1'b0, sq_root};
    rx_sh  = {rem_x, nx[16]};
    ry_sh  = {rem_y, ny[16]};
    qx     = {1'b0, nx[8:0]};
    qy     = {1'b0, ny[8:0]};
    if (scaled) begin
      fx = vx_raw[9] ? -$signed(qx) : $signed(qx);
      fy = vy_raw[9] ? -$signed(qy) : $signed(qy);
    end else begin
      fx = vx_raw;
      fy = vy_raw;
    end
    if (near && !fy[9] && (fy != 10'sd0)) begin
      fy = 10'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          state_next = ST_SQX;
        end
      end
      ST_SQX:  state_next = ST_SQY;
      ST_SQY:  state_next = ST_HDG;
      ST_HDG:  state_next = ST_SQRT;
      ST_SQRT: begin
        if (cnt == SQRT_STEPS - 5'd1) begin
          state_next = ST_MULX;
        end
      end
      ST_MULX: state_next = (sq_root > speed_limit) ? ST_MULY : ST_FIN;
      ST_MULY: state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == DIV_STEPS - 5'd1) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      side_mode   <= SIDE_MODE_RESET;
      speed_limit <= SPEED_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_SIDE_MODE:   side_mode   <= cfg_data[1:0];
        REG_SPEED_LIMIT: speed_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // heading state
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_rem <= '0;
      heading  <= '0;
    end else if (state == ST_HDG) begin
      turn_rem <= 5'(tr_sum);
      heading  <= hwrap[11:0];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          vx_raw <= vx_c;
          vy_raw <= vy_c;
          ax     <= ax_c[8:0];
          ay     <= ay_c[8:0];
          near   <= (distance_reading < NEAR_LIMIT);
          tdiff  <= tdiff_c;
          om_neg <= tdiff_c[8];
        end
      end
      ST_SQX: begin
        rad    <= mul_p;
        om_mag <= om_prod[15:10];
      end
      ST_SQY: begin
        rad     <= rad + mul_p;
        q10     <= q10_c;
        r10     <= 4'(om_mag - q_times);
        sq_rem  <= '0;
        sq_root <= '0;
      end
      ST_HDG: begin
        cnt <= '0;
      end
      ST_SQRT: begin
        cnt <= cnt + 5'd1;
        rad <= {rad[15:0], 2'b00};
        if (sq_acc >= sq_try) begin
          sq_rem  <= 10'(sq_acc - sq_try);
          sq_root <= {sq_root[7:0], 1'b1};
        end else begin
          sq_rem  <= sq_acc[9:0];
          sq_root <= {sq_root[7:0], 1'b0};
        end
      end
      ST_MULX: begin
        nx     <= mul_p[16:0];
        scaled <= (sq_root > speed_limit);
      end
      ST_MULY: begin
        ny    <= mul_p[16:0];
        rem_x <= '0;
        rem_y <= '0;
        cnt   <= '0;
      end
      ST_DIV: begin
        cnt <= cnt + 5'd1;
        if (rx_sh >= div_d) begin
          rem_x <= 9'(rx_sh - div_d);
          nx    <= {nx[15:0], 1'b1};
        end else begin
          rem_x <= rx_sh[8:0];
          nx    <= {nx[15:0], 1'b0};
        end
        if (ry_sh >= div_d) begin
          rem_y <= 9'(ry_sh - div_d);
          ny    <= {ny[15:0], 1'b1};
        end else begin
          rem_y <= ry_sh[8:0];
          ny    <= {ny[15:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      vel_x          <= fx;
      vel_y          <= fy;
      heading_target <= heading;
      near_flag      <= near;
    end
  end

endmodule : joystick_velocity_heading_shaper
`default_nettype wire
